FILE: design/ssdm_pkg.sv
// ----------------------------------------------------------------------------
// ssdm_pkg: shared types and constants for the suffix dictionary matcher
// Item payload structs, command and status codes, controller states.
// ----------------------------------------------------------------------------
package ssdm_pkg;

  localparam int NodeCount  = 4096;
  localparam int MaxWordLen = 64;
  localparam int Alphabet   = 26;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  typedef struct packed {
    logic       command;
    logic [4:0] letter;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_Q_RD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

endpackage

FILE: design/ssdm_ram.sv
// ----------------------------------------------------------------------------
// ssdm_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ssdm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: design/stream_suffix_dictionary_matcher_core.sv
// ----------------------------------------------------------------------------
// stream_suffix_dictionary_matcher_core: reversed-trie stream word matcher
// Loads words last letter first into a trie; matches word suffixes of a
// letter stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps the child table and end-mark memories to zero,
// one entry per cycle (the child table sets the length of the sweep) and
// takes no item meanwhile. Each item gives one result item. A load letter
// reads its child entry, then writes a newly allocated entry if that one is
// empty and the trie is not full; the write is skipped when the word is
// already dropped, the letter is rejected or the word is MaxWordLen letters
// long. A query walks at most MaxWordLen trie levels; each level reads the
// child table, then the end mark of the reached node, from single-port
// memories. The history ring is a small RAM read one level ahead; the newest
// letter comes straight from the item. The result is handed to an output
// register, so the next item is taken while it waits; only a result that
// is still waiting when the next one is done holds the block.
// ----------------------------------------------------------------------------
module stream_suffix_dictionary_matcher_core #(
  parameter int NodeCount  = ssdm_pkg::NodeCount,
  parameter int MaxWordLen = ssdm_pkg::MaxWordLen,
  parameter int Alphabet   = ssdm_pkg::Alphabet
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssdm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssdm_pkg::out_item_t out_data
);
  localparam int NW = (NodeCount > 2) ? $clog2(NodeCount) : 1;
  localparam int SlotCount = NodeCount * Alphabet;
  localparam int SW = $clog2(SlotCount);
  localparam int HW = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int LW = $clog2(MaxWordLen + 1);
  localparam int AW = $clog2(Alphabet);

  ssdm_pkg::state_t state, state_next;

  // registers
  logic [SW-1:0] clr_addr;
  logic [NW-1:0] nodes_used, cursor, node;
  logic [LW-1:0] load_length, fill, steps;
  logic          dropped;
  logic [HW-1:0] head, pos;
  ssdm_pkg::in_item_t item;
  ssdm_pkg::out_item_t result;
  ssdm_pkg::out_item_t out_item;
  logic          result_valid;

  // memory ports
  logic          ct_we, em_we, hist_we;
  logic [SW-1:0] ct_addr;
  logic [NW-1:0] em_addr;
  logic [NW-1:0] ct_wdata, ct_rdata;
  logic          em_wdata, em_rdata;
  logic [HW-1:0] hist_addr;
  logic [4:0]    hist_wdata, hist_rdata;

  ssdm_ram #(.Width(NW), .Depth(SlotCount)) u_child (
    .clk, .we(ct_we), .addr(ct_addr), .wdata(ct_wdata), .rdata(ct_rdata));
  ssdm_ram #(.Width(1), .Depth(NodeCount)) u_mark (
    .clk, .we(em_we), .addr(em_addr), .wdata(em_wdata), .rdata(em_rdata));
  ssdm_ram #(.Width(5), .Depth(MaxWordLen)) u_hist (
    .clk, .we(hist_we), .addr(hist_addr), .wdata(hist_wdata), .rdata(hist_rdata));

  logic [4:0]  hletter;
  logic        letter_ok;
  logic [SW-1:0] slot_base;
  logic [HW-1:0] pos_prev;
  // first level uses the letter just taken; later levels were read ahead
  assign hletter   = (steps == '0) ? item.letter : hist_rdata;
  assign letter_ok = ({27'd0, item.letter} < 32'(Alphabet));
  // node*Alphabet: one multiply by a constant
  assign slot_base = SW'(node * Alphabet);
  assign pos_prev  = (pos == '0) ? HW'(MaxWordLen - 1) : pos - 1'b1;

  assign in_ready  = (state == ssdm_pkg::ST_IDLE);
  assign out_valid = result_valid;
  assign out_data  = out_item;

  logic full;
  assign full = (32'(nodes_used) + 32'd1 >= 32'(NodeCount));

  // result leaves DONE once the output register is free or being emptied
  logic done_go;
  assign done_go = (state == ssdm_pkg::ST_DONE) && (!result_valid || out_ready);

  // mark write on a load word end, only if not dropped and past the root
  logic mark_now;
  assign mark_now = done_go && item.command == ssdm_pkg::CMD_LOAD &&
                    item.word_end && !dropped && cursor != '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ssdm_pkg::ST_CLEAR:
        if (clr_addr == SW'(SlotCount - 1)) state_next = ssdm_pkg::ST_IDLE;
      ssdm_pkg::ST_IDLE:
        if (in_valid && in_ready) begin
          state_next = (in_data.command == ssdm_pkg::CMD_QUERY) ?
                       ssdm_pkg::ST_Q_RD : ssdm_pkg::ST_LOAD_RD;
        end
      ssdm_pkg::ST_LOAD_RD: begin
        if (dropped || !letter_ok || load_length == LW'(MaxWordLen))
          state_next = ssdm_pkg::ST_DONE;
        else
          state_next = ssdm_pkg::ST_LOAD_WR;
      end
      ssdm_pkg::ST_LOAD_WR: state_next = ssdm_pkg::ST_DONE;
      ssdm_pkg::ST_Q_RD: begin
        // end mark of the node reached last cycle wins first
        if (steps != '0 && em_rdata)
          state_next = ssdm_pkg::ST_DONE;
        else if (steps == fill || hletter >= 5'(Alphabet))
          state_next = ssdm_pkg::ST_DONE;
        else
          state_next = ssdm_pkg::ST_Q_CHK;
      end
      ssdm_pkg::ST_Q_CHK: begin
        if (ct_rdata == '0) state_next = ssdm_pkg::ST_DONE;
        else state_next = ssdm_pkg::ST_Q_RD;
      end
      ssdm_pkg::ST_DONE:
        if (done_go) state_next = ssdm_pkg::ST_IDLE;
      default: state_next = ssdm_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    ct_we      = 1'b0;
    ct_addr    = slot_base + SW'(item.letter[AW-1:0]);
    ct_wdata   = NW'(nodes_used + 1'b1);
    em_we      = 1'b0;
    em_addr    = cursor;
    em_wdata   = 1'b1;
    hist_we    = 1'b0;
    hist_addr  = pos;
    hist_wdata = in_data.letter;
    case (state)
      ssdm_pkg::ST_CLEAR: begin
        ct_we = 1'b1; ct_addr = clr_addr; ct_wdata = '0;
        em_we = (clr_addr < SW'(NodeCount)); em_addr = NW'(clr_addr); em_wdata = 1'b0;
      end
      ssdm_pkg::ST_IDLE: begin
        hist_we   = in_valid && in_ready && (in_data.command == ssdm_pkg::CMD_QUERY);
        hist_addr = head;
      end
      ssdm_pkg::ST_LOAD_WR: ct_we = (ct_rdata == '0) && !full;
      ssdm_pkg::ST_Q_RD: ct_addr = slot_base + SW'(hletter[AW-1:0]);
      ssdm_pkg::ST_Q_CHK: begin
        em_addr   = ct_rdata;
        hist_addr = pos_prev;
      end
      ssdm_pkg::ST_DONE: begin
        em_addr = cursor;
        em_we   = mark_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssdm_pkg::ST_CLEAR;
      clr_addr <= '0;
      nodes_used <= '0; cursor <= '0; load_length <= '0; dropped <= 1'b0;
      head <= '0; fill <= '0; result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done_go) result_valid <= 1'b1;
      else if (out_valid && out_ready) result_valid <= 1'b0;
      case (state)
        ssdm_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ssdm_pkg::ST_IDLE:
          if (in_valid && in_ready) begin
            item <= in_data;
            result <= '0;
            if (in_data.command == ssdm_pkg::CMD_QUERY) begin
              node <= '0;
              pos <= head;
              steps <= '0;
              head <= (32'(head) + 1 >= MaxWordLen) ? '0 : head + 1'b1;
              if (fill != LW'(MaxWordLen)) fill <= fill + 1'b1;
            end else begin
              node <= cursor;
            end
          end
        ssdm_pkg::ST_LOAD_RD:
          if (!dropped) begin
            if (!letter_ok) dropped <= 1'b1;
            else if (load_length == LW'(MaxWordLen)) begin
              dropped <= 1'b1; result.status <= ssdm_pkg::STATUS_LONG;
            end
          end
        ssdm_pkg::ST_LOAD_WR:
          if (ct_rdata != '0) begin
            cursor <= ct_rdata; load_length <= load_length + 1'b1;
          end else if (full) begin
            dropped <= 1'b1; result.status <= ssdm_pkg::STATUS_FULL;
          end else begin
            nodes_used <= nodes_used + 1'b1;
            cursor <= nodes_used + 1'b1;
            load_length <= load_length + 1'b1;
          end
        ssdm_pkg::ST_Q_RD:
          // end mark of the node reached last cycle
          if (steps != '0 && em_rdata) result.matched <= 1'b1;
        ssdm_pkg::ST_Q_CHK:
          if (ct_rdata != '0) begin
            node <= ct_rdata;
            steps <= steps + 1'b1;
            pos <= pos_prev;
          end
        ssdm_pkg::ST_DONE:
          if (done_go) begin
            out_item <= result;
            if (item.command == ssdm_pkg::CMD_LOAD && item.word_end) begin
              cursor <= '0; load_length <= '0; dropped <= 1'b0;
            end
          end
        default: ;
      endcase
    end
  end
endmodule
